[src/satlb_pkg.sv]
// ----------------------------------------------------------------------------
// satlb_pkg
// Shared types and constants for the set-associative TLB with round-robin fill.
// ----------------------------------------------------------------------------
package satlb_pkg;

   // parameter defaults
   localparam int NUM_SETS_DEF     = 32;
   localparam int WAYS_PER_SET_DEF = 32;
   localparam int VPN_BITS_DEF     = 20;

   // request / response field widths
   localparam int MODE_W  = 2;
   localparam int VA_W    = 20;
   localparam int PA_W    = 32;
   localparam int FLAGS_W = 4;
   localparam int SEL_W   = 5;
   localparam int TAG_W   = 24;

   // number of values of the low set-select bits of a virtual page
   localparam int SEL_COUNT = 1 << SEL_W;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 88;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_FILL    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INV_ONE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INV_ALL = 2'd2;

   // clears the valid bit (bit 0) of the flags
   localparam logic [FLAGS_W-1:0] VALID_CLEAR_MASK = 4'b1110;

   // command from the sequencer to the per-set pointer block
   typedef struct packed {
      logic advance;     // step the pointer of the addressed set
      logic clear_all;   // zero every pointer and full flag
   } ptr_cmd_type;

endpackage

[src/satlb_ram.sv]
// ----------------------------------------------------------------------------
// satlb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module satlb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/satlb_way_ptr.sv]
// ----------------------------------------------------------------------------
// satlb_way_ptr
// Per-set round-robin way pointer and full flag.
// ----------------------------------------------------------------------------
module satlb_way_ptr #(
   parameter int NUM_SETS     = satlb_pkg::NUM_SETS_DEF,
   parameter int WAYS_PER_SET = satlb_pkg::WAYS_PER_SET_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  satlb_pkg::ptr_cmd_type      cmd,
   input  logic [$clog2(NUM_SETS)-1:0] set_idx,
   output logic [$clog2(WAYS_PER_SET)-1:0] way,
   output logic                        full
);

   localparam int WAY_W = $clog2(WAYS_PER_SET);

   logic [WAY_W-1:0]    next_way_ff [NUM_SETS];
   logic [WAY_W-1:0]    next_way_in [NUM_SETS];
   logic [NUM_SETS-1:0] full_ff;
   logic [NUM_SETS-1:0] full_in;

   assign way  = next_way_ff[set_idx];
   assign full = full_ff[set_idx];

   always_comb begin
      next_way_in = next_way_ff;
      full_in     = full_ff;
      priority if (cmd.clear_all) begin
         for (int i = 0; i < NUM_SETS; i++) begin
            next_way_in[i] = '0;
         end
         full_in = '0;
      end else if (cmd.advance) begin
         // wrap marks the set full until the next invalidate-all or reset
         if (next_way_ff[set_idx] == WAY_W'(WAYS_PER_SET - 1)) begin
            next_way_in[set_idx] = '0;
            full_in[set_idx]     = 1'b1;
         end else begin
            next_way_in[set_idx] = next_way_ff[set_idx] + 1'b1;
         end
      end else begin
         // hold
         next_way_in = next_way_ff;
         full_in     = full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_way_ff <= '{default: '0};
         full_ff     <= '0;
      end else begin
         next_way_ff <= next_way_in;
         full_ff     <= full_in;
      end
   end

endmodule

[src/set_assoc_tlb_fifo_fill.sv]
// ----------------------------------------------------------------------------
// set_assoc_tlb_fifo_fill
// Set-associative translation table with round-robin fill and invalidation.
// ----------------------------------------------------------------------------
// The table holds NUM_SETS x WAYS_PER_SET entries in one single-port-per-
// direction RAM (virtual page, physical page, 4 flag bits with bit 0 valid).
// A request either fills an entry (set from the low virtual page bits, way
// from the set's round-robin pointer), invalidates one entry, or invalidates
// all. Each request yields exactly one response. A fill or an in-range
// invalidate-one passes a lookup state, which reads the entry, and then an
// update state, which writes it back and loads the response register.
// An out-of-range invalidate-one or an unused mode answers from the lookup
// state without reading the RAM. Invalidate-all walks every entry with a
// read and a write per entry, then answers. After reset the block runs a
// clearing pass that writes zero to all NUM_SETS*WAYS_PER_SET entries (1024
// at default sizes) with req_tready low. One request is in work at a time;
// req_tready is high only while idle. A response that waits in the output
// register stalls the block only when the next response is ready to be
// loaded.
// ----------------------------------------------------------------------------
module set_assoc_tlb_fifo_fill #(
   parameter int NUM_SETS     = satlb_pkg::NUM_SETS_DEF,
   parameter int WAYS_PER_SET = satlb_pkg::WAYS_PER_SET_DEF,
   parameter int VPN_BITS     = satlb_pkg::VPN_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // mode[1:0], virt_page[21:2], phys_page[53:22], entry_flags[57:54],
   // allow_replace[58], target_set[63:59], target_way[68:64], zero fill
   input  logic [satlb_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status[0], set_used[5:1], way_used[10:6], evicted[11],
   // old_virt_page[31:12], old_phys_page[63:32], tag_word[87:64]
   output logic [satlb_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int SET_W     = $clog2(NUM_SETS);
   localparam int WAY_W     = $clog2(WAYS_PER_SET);
   localparam int N_ENTRIES = NUM_SETS * WAYS_PER_SET;
   localparam int ADDR_W    = $clog2(N_ENTRIES);
   localparam int PA_W      = satlb_pkg::PA_W;
   localparam int FLAGS_W   = satlb_pkg::FLAGS_W;
   localparam int VA_W      = satlb_pkg::VA_W;
   localparam int SEL_W     = satlb_pkg::SEL_W;
   localparam int TAG_W     = satlb_pkg::TAG_W;
   localparam int ENTRY_W   = VPN_BITS + PA_W + FLAGS_W;
   localparam int PPN_LSB   = FLAGS_W;
   localparam int VPN_LSB   = FLAGS_W + PA_W;

   // sequencer states
   localparam logic [2:0] ST_CLEAR   = 3'd0;  // post-reset RAM clear
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_LOOK    = 3'd2;  // pick entry, issue read
   localparam logic [2:0] ST_UPDATE  = 3'd3;  // write back, load response
   localparam logic [2:0] ST_WALK_RD = 3'd4;  // invalidate-all read
   localparam logic [2:0] ST_WALK_WR = 3'd5;  // invalidate-all write
   localparam logic [2:0] ST_RESP    = 3'd6;  // invalidate-all response

   // set index for each value of the low virtual page bits (mod NUM_SETS)
   function automatic logic [satlb_pkg::SEL_COUNT*SET_W-1:0] build_set_table();
      logic [satlb_pkg::SEL_COUNT*SET_W-1:0] tbl;
      int r;
      tbl = '0;
      for (int v = 0; v < satlb_pkg::SEL_COUNT; v++) begin
         r = v;
         for (int k = 0; k < satlb_pkg::SEL_COUNT; k++) begin
            if (r >= NUM_SETS) begin
               r = r - NUM_SETS;
            end
         end
         tbl[v*SET_W +: SET_W] = SET_W'(r);
      end
      return tbl;
   endfunction

   localparam logic [satlb_pkg::SEL_COUNT*SET_W-1:0] SET_TABLE = build_set_table();

   // ---- control registers ----
   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // ---- request capture ----
   logic [satlb_pkg::MODE_W-1:0] mode_ff;
   logic [VA_W-1:0]              vpn_ff;
   logic [PA_W-1:0]              ppn_ff;
   logic [FLAGS_W-1:0]           flags_ff;
   logic                         repl_ff;
   logic [SEL_W-1:0]             tset_ff;
   logic [SEL_W-1:0]             tway_ff;

   // ---- entry selected by the lookup ----
   logic [SET_W-1:0]  set_ff, set_in;
   logic [WAY_W-1:0]  way_ff, way_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              hit_full_ff, hit_full_in;

   // ---- response register ----
   logic              rsp_status_ff;
   logic [SEL_W-1:0]  rsp_set_ff;
   logic [SEL_W-1:0]  rsp_way_ff;
   logic              rsp_evict_ff;
   logic [VA_W-1:0]   rsp_old_vpn_ff;
   logic [PA_W-1:0]   rsp_old_ppn_ff;
   logic [TAG_W-1:0]  rsp_tag_ff;

   logic              load_out;
   logic              out_status;
   logic [SEL_W-1:0]  out_set;
   logic [SEL_W-1:0]  out_way;
   logic              out_evict;
   logic [VA_W-1:0]   out_old_vpn;
   logic [PA_W-1:0]   out_old_ppn;
   logic [TAG_W-1:0]  out_tag;

   // ---- datapath ----
   logic                   req_accept;
   logic                   out_free;
   logic                   cnt_last;
   logic                   in_range;
   logic                   look_is_fill;
   logic [SET_W-1:0]       fill_set;
   logic [SET_W-1:0]       a_set;
   logic [WAY_W-1:0]       a_way;
   logic [ADDR_W-1:0]      look_addr;
   logic [SET_W-1:0]       ptr_set;
   logic [WAY_W-1:0]       ptr_way;
   logic                   ptr_full;
   satlb_pkg::ptr_cmd_type ptr_cmd;

   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   logic [ENTRY_W-1:0]     ram_wr_data;
   logic                   ram_rd_en;
   logic [ADDR_W-1:0]      ram_rd_addr;
   logic [ENTRY_W-1:0]     ram_rd_data;

   logic [VPN_BITS-1:0]    ent_vpn;
   logic [PA_W-1:0]        ent_ppn;
   logic [FLAGS_W-1:0]     ent_flags;
   logic [FLAGS_W-1:0]     inv_flags;
   logic [VPN_BITS-1:0]    new_vpn;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cnt_last   = (cnt_ff == ADDR_W'(N_ENTRIES - 1));

   // lookup: fills take their set from the low page bits, their way from
   // the pointer; invalidate-one takes both from the request
   assign look_is_fill = (mode_ff == satlb_pkg::MODE_FILL);
   assign fill_set     = SET_TABLE[vpn_ff[SEL_W-1:0]*SET_W +: SET_W];
   assign in_range     = (32'(tset_ff) < 32'(NUM_SETS)) &&
                         (32'(tway_ff) < 32'(WAYS_PER_SET));
   assign a_set        = look_is_fill ? fill_set : SET_W'(tset_ff);
   assign a_way        = look_is_fill ? ptr_way  : WAY_W'(tway_ff);
   assign look_addr    = ADDR_W'(a_set) * ADDR_W'(WAYS_PER_SET) + ADDR_W'(a_way);
   assign ptr_set      = (state_ff == ST_LOOK) ? fill_set : set_ff;

   assign ent_vpn   = ram_rd_data[ENTRY_W-1:VPN_LSB];
   assign ent_ppn   = ram_rd_data[VPN_LSB-1:PPN_LSB];
   assign ent_flags = ram_rd_data[FLAGS_W-1:0];
   assign inv_flags = ent_flags & satlb_pkg::VALID_CLEAR_MASK;
   assign new_vpn   = VPN_BITS'(vpn_ff);

   assign ram_rd_addr = (state_ff == ST_WALK_RD) ? cnt_ff : look_addr;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      set_in       = set_ff;
      way_in       = way_ff;
      addr_in      = addr_ff;
      hit_full_in  = hit_full_ff;
      load_out     = 1'b0;
      out_status   = 1'b0;
      out_set      = '0;
      out_way      = '0;
      out_evict    = 1'b0;
      out_old_vpn  = '0;
      out_old_ppn  = '0;
      out_tag      = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cnt_ff;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ptr_cmd      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_LOOK;
            end
         end

         ST_LOOK: begin
            unique case (mode_ff)
               satlb_pkg::MODE_FILL: begin
                  ram_rd_en   = 1'b1;
                  set_in      = fill_set;
                  way_in      = ptr_way;
                  addr_in     = look_addr;
                  hit_full_in = ptr_full;
                  state_in    = ST_UPDATE;
               end
               satlb_pkg::MODE_INV_ONE: begin
                  if (in_range) begin
                     ram_rd_en = 1'b1;
                     set_in    = SET_W'(tset_ff);
                     way_in    = WAY_W'(tway_ff);
                     addr_in   = look_addr;
                     state_in  = ST_UPDATE;
                  end else if (out_free) begin
                     // out of range: echo the target, nothing else
                     load_out = 1'b1;
                     out_set  = tset_ff;
                     out_way  = tway_ff;
                     state_in = ST_IDLE;
                  end
               end
               satlb_pkg::MODE_INV_ALL: begin
                  ptr_cmd.clear_all = 1'b1;
                  cnt_in            = '0;
                  state_in          = ST_WALK_RD;
               end
               default: begin
                  if (out_free) begin
                     load_out = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end

         ST_UPDATE: begin
            if (out_free) begin
               load_out = 1'b1;
               out_set  = SEL_W'(set_ff);
               out_way  = SEL_W'(way_ff);
               state_in = ST_IDLE;
               priority if (look_is_fill) begin
                  if (hit_full_ff && !repl_ff) begin
                     out_status = 1'b1;   // set full, no replacement
                  end else begin
                     ram_wr_en       = 1'b1;
                     ram_wr_addr     = addr_ff;
                     ram_wr_data     = {new_vpn, ppn_ff, flags_ff};
                     ptr_cmd.advance = 1'b1;
                     out_evict       = hit_full_ff;
                     out_tag         = {VA_W'(new_vpn), flags_ff};
                     if (hit_full_ff) begin
                        out_old_vpn = VA_W'(ent_vpn);
                        out_old_ppn = ent_ppn;
                     end
                  end
               end else begin
                  // invalidate one: keep page numbers, drop valid
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = addr_ff;
                  ram_wr_data = {ent_vpn, ent_ppn, inv_flags};
                  out_evict   = 1'b1;
                  out_old_vpn = VA_W'(ent_vpn);
                  out_old_ppn = ent_ppn;
                  out_tag     = {VA_W'(ent_vpn), inv_flags};
               end
            end
         end

         ST_WALK_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_WALK_WR;
         end

         ST_WALK_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {ram_rd_data[ENTRY_W-1:FLAGS_W], inv_flags};
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_RESP;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_WALK_RD;
            end
         end

         ST_RESP: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff  <= req_tdata[1:0];
         vpn_ff   <= req_tdata[21:2];
         ppn_ff   <= req_tdata[53:22];
         flags_ff <= req_tdata[57:54];
         repl_ff  <= req_tdata[58];
         tset_ff  <= req_tdata[63:59];
         tway_ff  <= req_tdata[68:64];
      end
      set_ff      <= set_in;
      way_ff      <= way_in;
      addr_ff     <= addr_in;
      hit_full_ff <= hit_full_in;
      if (load_out) begin
         rsp_status_ff  <= out_status;
         rsp_set_ff     <= out_set;
         rsp_way_ff     <= out_way;
         rsp_evict_ff   <= out_evict;
         rsp_old_vpn_ff <= out_old_vpn;
         rsp_old_ppn_ff <= out_old_ppn;
         rsp_tag_ff     <= out_tag;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_tag_ff, rsp_old_ppn_ff, rsp_old_vpn_ff, rsp_evict_ff,
                        rsp_way_ff, rsp_set_ff, rsp_status_ff};

   // per-set round-robin pointers and full flags
   satlb_way_ptr #(
      .NUM_SETS     (NUM_SETS),
      .WAYS_PER_SET (WAYS_PER_SET)
   ) u_way_ptr (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ptr_cmd),
      .set_idx (ptr_set),
      .way     (ptr_way),
      .full    (ptr_full)
   );

   // entry store: {virt_page, phys_page, flags}
   satlb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (N_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
